@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo chorus package
// Shared constants, register indexes and output rounding for the chorus.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int LINE_DEPTH_DEF = 16384;
  localparam int SINE_BITS_DEF  = 10;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int VOICE_W  = 44;
  localparam int DIFF_W   = 45;
  localparam int ACC_W    = 60;

  localparam logic [IDX_W-1:0] REG_MIX    = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEREO = 3'd1;
  localparam logic [IDX_W-1:0] REG_PSTEP  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPREAD = 3'd3;
  localparam logic [IDX_W-1:0] REG_LBASE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RBASE  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SWEEP  = 3'd6;

  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42334;
  localparam logic [16:0] SIN_C = 17'd5223;
  localparam logic [16:0] SIN_D = 17'd307;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [17:0] MIX_TWO = 18'd131072;
  localparam logic [23:0] READ_LAG = 24'd768;
  localparam int RECIP_SHIFT = 39;

  localparam logic [16:0] MIX_RST    = 17'd6554;
  localparam logic [16:0] STEREO_RST = 17'd0;
  localparam logic [31:0] PSTEP_RST  = 32'd8948;
  localparam logic [30:0] SPREAD_RST = 31'd0;
  localparam logic [21:0] BASE_RST   = 22'd245760;
  localparam logic [21:0] SWEEP_RST  = 22'd12288;
  localparam logic [31:0] PHASE2_RST = 32'h8000_0000;

  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] rnd;
    logic [17:0]      r;
    logic [SAMPLE_W-1:0] res;
    mag = v[ACC_W-1] ? (~v + 1'b1) : v;
    rnd = mag + (ACC_W'(1) << 41);
    r   = rnd[59:42];
    if (v[ACC_W-1]) begin
      res = (r > 18'd32768) ? 16'h8000 : SAMPLE_W'(~r + 1'b1);
    end else begin
      res = (r > 18'd32767) ? 16'h7fff : r[15:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/scd_ifs.sv @@
// ----------------------------------------------------------------------------
// Stereo chorus channels
// Valid/ready channels for input samples, stereo results and register writes.
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface scd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface scd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/scd_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module scd_mul
  import scd_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

@@ rtl/scd_ram.sv @@
// ----------------------------------------------------------------------------
// Delay memory
// One write port and one registered read port holding the sample history.
// ----------------------------------------------------------------------------
module scd_ram
  import scd_pkg::*;
#(
  parameter int DEPTH = LINE_DEPTH_DEF,
  parameter int AW    = $clog2(LINE_DEPTH_DEF)
)(
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0] rdata_r
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/stereo_chorus_delay_line.sv @@
// ----------------------------------------------------------------------------
// Stereo chorus delay line
// Two LFO voices read an interpolated delay line, blend against the dry
// sample and spread the pair into left and right outputs.
// ----------------------------------------------------------------------------
//   channel | direction | payload
//   in_ch   | sink      | in_sample
//   out_ch  | source    | left_sample, right_sample
//   cfg_ch  | sink      | reg_index, wr_data
//
// The result is worked out in steps that share one multiplier: fourteen
// steps per voice and four to combine the voices. No new item is taken until
// the result has been written to the output register and the line advanced.
// After reset a clearing pass writes zeros to every memory address, during
// which no item is taken. A waiting result stalls only the final step;
// register writes are taken in every cycle.
module stereo_chorus_delay_line
  import scd_pkg::*;
#(
  parameter int LINE_DEPTH      = LINE_DEPTH_DEF,
  parameter int SINE_INDEX_BITS = SINE_BITS_DEF
)(
  input  logic clk,
  input  logic rst_n,
  scd_in_if.sink    in_ch,
  scd_out_if.source out_ch,
  scd_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = AW + 10;
  localparam int QB = SINE_INDEX_BITS - 2;
  localparam logic [PW-1:0] SPAN = PW'(LINE_DEPTH * 256);
  localparam longint RECIP = (64'd1 << RECIP_SHIFT) / (LINE_DEPTH * 256);

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_T     = 5'd2;
  localparam logic [4:0] ST_T2    = 5'd3;
  localparam logic [4:0] ST_PC    = 5'd4;
  localparam logic [4:0] ST_PB    = 5'd5;
  localparam logic [4:0] ST_PA    = 5'd6;
  localparam logic [4:0] ST_SIN   = 5'd7;
  localparam logic [4:0] ST_DLY   = 5'd8;
  localparam logic [4:0] ST_QT    = 5'd9;
  localparam logic [4:0] ST_POS   = 5'd10;
  localparam logic [4:0] ST_RDA   = 5'd11;
  localparam logic [4:0] ST_RDB   = 5'd12;
  localparam logic [4:0] ST_WET   = 5'd13;
  localparam logic [4:0] ST_DRY   = 5'd14;
  localparam logic [4:0] ST_SUM   = 5'd15;
  localparam logic [4:0] ST_SPL   = 5'd16;
  localparam logic [4:0] ST_SPH   = 5'd17;
  localparam logic [4:0] ST_OUT   = 5'd18;
  localparam logic [4:0] ST_FIN   = 5'd19;

  logic [4:0] state_r, state_nxt;

  logic [16:0] mix_r, stereo_r;
  logic [31:0] pstep_r;
  logic [30:0] spread_r;
  logic [21:0] lbase_r, rbase_r, sweep_r;
  logic [16:0] mix_c, st_c;

  logic [31:0] ph1_r, ph2_r;
  logic [AW-1:0] wp_r, clr_r;
  logic        voice_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [1:0]  quad_r;
  logic [16:0] t_r, t2_r;
  logic [23:0] xd_r;
  logic [7:0]  f_r;
  logic [AW-1:0] nx_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [24:0] wet_r;
  logic signed [VOICE_W-1:0] acc_r, s1_r, s2_r;
  logic signed [PROD_W-1:0]  plo_r;
  logic signed [ACC_W-1:0]   pfin_r;
  logic        out_valid_r;
  logic [SAMPLE_W-1:0] left_r, right_r;

  logic                      mul_en;
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic signed [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  logic [31:0] phase_c;
  logic [21:0] base_c;
  logic [SINE_INDEX_BITS-1:0] sidx;
  logic [16:0] t_c, p_c, u_c;
  logic [17:0] pw_c;
  logic [23:0] xd_c, rem_a;
  logic [PW-1:0] rem_b, pos_a, pos_c;
  logic [AW-1:0] ip_c;
  logic signed [16:0] dlt_c;
  logic signed [VOICE_W-1:0] s_c;
  logic signed [DIFF_W-1:0]  d_c;
  logic signed [ACC_W-1:0]   sum_c;
  logic        out_free;
  logic [31:0] step_a, step_b;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.left_sample  = left_r;
  assign out_ch.right_sample = right_r;
  assign out_free = !out_valid_r || out_ch.ready;

  assign mix_c = (mix_r > Q16_ONE) ? Q16_ONE : mix_r;
  assign st_c  = (stereo_r > Q16_ONE) ? Q16_ONE : stereo_r;

  scd_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  scd_ram #(.DEPTH(LINE_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_comb begin
    phase_c = voice_r ? ph2_r : ph1_r;
    base_c  = voice_r ? rbase_r : lbase_r;
    sidx    = phase_c[31 -: SINE_INDEX_BITS];
    t_c     = 17'(sidx[QB-1:0]) << (16 - QB);
    if (sidx[SINE_INDEX_BITS-2]) begin
      t_c = Q16_ONE - t_c;
    end
    pw_c = prod[33:16];
    p_c  = (pw_c > 18'(Q16_ONE)) ? Q16_ONE : pw_c[16:0];
    u_c  = quad_r[1] ? 17'((18'(Q16_ONE) - 18'(p_c)) >> 1)
                     : 17'((18'(Q16_ONE) + 18'(p_c)) >> 1);
    xd_c  = 24'(base_c) + 24'(prod[37:16]) + READ_LAG;
    rem_a = xd_r - {prod[15:0], 8'h00};
    rem_b = (PW'(rem_a) >= SPAN) ? PW'(rem_a) - SPAN : PW'(rem_a);
    pos_a = PW'({wp_r, 8'h00}) + SPAN - rem_b;
    pos_c = (pos_a >= SPAN) ? pos_a - SPAN : pos_a;
    ip_c  = pos_c[AW+7:8];
    dlt_c = 17'(ram_rdata) - 17'(a_r);
    s_c   = acc_r + VOICE_W'(prod);
    d_c   = DIFF_W'(s1_r) - DIFF_W'(s2_r);
    sum_c = (ACC_W'(s1_r) + ACC_W'(s2_r)) <<< 16;
    step_a = pstep_r + 32'(spread_r);
    step_b = pstep_r - 32'(spread_r);
  end

  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    case (state_r)
      ST_T: begin
        mul_en = 1'b1;
        op_a = MUL_W'(t_c);
        op_b = MUL_W'(t_c);
      end
      ST_T2: begin
        mul_en = 1'b1;
        op_a = MUL_W'(prod[32:16]);
        op_b = MUL_W'(SIN_D);
      end
      ST_PC: begin
        mul_en = 1'b1;
        op_a = MUL_W'(t2_r);
        op_b = MUL_W'(SIN_C - prod[32:16]);
      end
      ST_PB: begin
        mul_en = 1'b1;
        op_a = MUL_W'(t2_r);
        op_b = MUL_W'(SIN_B - prod[32:16]);
      end
      ST_PA: begin
        mul_en = 1'b1;
        op_a = MUL_W'(t_r);
        op_b = MUL_W'(SIN_A - prod[32:16]);
      end
      ST_SIN: begin
        mul_en = 1'b1;
        op_a = MUL_W'(sweep_r);
        op_b = MUL_W'(u_c);
      end
      ST_DLY: begin
        mul_en = 1'b1;
        op_a = MUL_W'(xd_c);
        op_b = MUL_W'(RECIP);
      end
      ST_QT: begin
        mul_en = 1'b1;
        op_a = MUL_W'(prod[47:RECIP_SHIFT]);
        op_b = MUL_W'(LINE_DEPTH);
      end
      ST_RDB: begin
        mul_en = 1'b1;
        op_a = MUL_W'(f_r);
        op_b = MUL_W'(dlt_c);
      end
      ST_WET: begin
        mul_en = 1'b1;
        op_a = MUL_W'(MIX_TWO - 18'(mix_c));
        op_b = MUL_W'(x_r);
      end
      ST_DRY: begin
        mul_en = 1'b1;
        op_a = MUL_W'(mix_c);
        op_b = wet_r;
      end
      ST_SPL: begin
        mul_en = 1'b1;
        op_a = MUL_W'(st_c);
        op_b = MUL_W'(d_c[23:0]);
      end
      ST_SPH: begin
        mul_en = 1'b1;
        op_a = MUL_W'(st_c);
        op_b = MUL_W'($signed(d_c[DIFF_W-1:24]));
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = x_r;
    ram_raddr = (state_r == ST_RDA) ? nx_r : ip_c;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_FIN && out_free) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(LINE_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_T;
      ST_T:     state_nxt = ST_T2;
      ST_T2:    state_nxt = ST_PC;
      ST_PC:    state_nxt = ST_PB;
      ST_PB:    state_nxt = ST_PA;
      ST_PA:    state_nxt = ST_SIN;
      ST_SIN:   state_nxt = ST_DLY;
      ST_DLY:   state_nxt = ST_QT;
      ST_QT:    state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_RDA;
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB:   state_nxt = ST_WET;
      ST_WET:   state_nxt = ST_DRY;
      ST_DRY:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = voice_r ? ST_SPL : ST_T;
      ST_SPL:   state_nxt = ST_SPH;
      ST_SPH:   state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      ph1_r       <= '0;
      ph2_r       <= PHASE2_RST;
      voice_r     <= 1'b0;
      out_valid_r <= 1'b0;
      mix_r       <= MIX_RST;
      stereo_r    <= STEREO_RST;
      pstep_r     <= PSTEP_RST;
      spread_r    <= SPREAD_RST;
      lbase_r     <= BASE_RST;
      rbase_r     <= BASE_RST;
      sweep_r     <= SWEEP_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          REG_MIX:    mix_r    <= cfg_ch.wr_data[16:0];
          REG_STEREO: stereo_r <= cfg_ch.wr_data[16:0];
          REG_PSTEP:  pstep_r  <= cfg_ch.wr_data;
          REG_SPREAD: spread_r <= cfg_ch.wr_data[30:0];
          REG_LBASE:  lbase_r  <= cfg_ch.wr_data[21:0];
          REG_RBASE:  rbase_r  <= cfg_ch.wr_data[21:0];
          REG_SWEEP:  sweep_r  <= cfg_ch.wr_data[21:0];
          default:    ;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && in_ch.valid) begin
        voice_r <= 1'b0;
      end
      if (state_r == ST_SUM) begin
        voice_r <= 1'b1;
      end
      if (state_r == ST_FIN && out_free) begin
        ph1_r <= ph1_r + step_a;
        ph2_r <= ph2_r + ((st_c > 17'd32768) ? step_b : step_a);
        wp_r  <= (wp_r == AW'(LINE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      x_r <= in_ch.in_sample;
    end
    if (state_r == ST_T) begin
      t_r    <= t_c;
      quad_r <= sidx[SINE_INDEX_BITS-1 -: 2];
    end
    if (state_r == ST_T2) begin
      t2_r <= prod[32:16];
    end
    if (state_r == ST_DLY) begin
      xd_r <= xd_c;
    end
    if (state_r == ST_POS) begin
      f_r  <= pos_c[7:0];
      nx_r <= (ip_c == AW'(LINE_DEPTH - 1)) ? '0 : ip_c + 1'b1;
    end
    if (state_r == ST_RDA) begin
      a_r <= ram_rdata;
    end
    if (state_r == ST_WET) begin
      wet_r <= (25'(a_r) <<< 8) + 25'(prod);
    end
    if (state_r == ST_DRY) begin
      acc_r <= VOICE_W'(prod) <<< 8;
    end
    if (state_r == ST_SUM) begin
      if (voice_r) begin
        s2_r <= s_c;
      end else begin
        s1_r <= s_c;
      end
    end
    if (state_r == ST_SPH) begin
      plo_r <= prod;
    end
    if (state_r == ST_OUT) begin
      pfin_r <= ACC_W'(plo_r) + (ACC_W'(prod) <<< 24);
    end
    if (state_r == ST_FIN && out_free) begin
      left_r  <= round_sat(sum_c + pfin_r);
      right_r <= round_sat(sum_c - pfin_r);
    end
  end

endmodule
